FILE: hdl/nds_pkg.sv
// Package for the nearest direction search unit.
// Field widths, request and status codes, state encoding and the Q2.28 to Q1.14 rounding helper.
// No dependencies.
`default_nettype none

package nds_pkg;

    // Payload widths
    localparam int REQ_W      = 2;
    localparam int COMP_W     = 16;              // Q1.14 component
    localparam int STATUS_W   = 2;
    localparam int IDX_OUT_W  = 10;
    localparam int CNT_OUT_W  = 11;

    localparam int DEF_MAX_POINTS = 1024;

    // Arithmetic widths
    localparam int PROD_W = 2 * COMP_W;          // Q2.28 product
    localparam int SUM_W  = PROD_W + 3;          // rotation sums with headroom
    localparam int DIFF_W = COMP_W + 1;          // component difference
    localparam int SQ_W   = 2 * COMP_W;          // squared difference, unsigned
    localparam int DIST_W = SQ_W + 2;            // sum of three squares

    localparam int RND_SHIFT = 14;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT_MUL,
        S_ROT_SUM,
        S_ROT_RND,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } point_t;

    // Round half up from Q2.28 to Q1.14, then saturate to 16 bits signed.
    function automatic logic signed [COMP_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] q;
        logic signed [COMP_W-1:0] res;
        r = s + SUM_W'(1 << (RND_SHIFT - 1));
        q = r >>> RND_SHIFT;
        if (q > SUM_W'(32767))
            res = COMP_W'(32767);
        else if (q < -SUM_W'(32768))
            res = COMP_W'(-32768);
        else
            res = q[COMP_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/nearest_direction_search_unit.sv
// Nearest direction search unit: point table in a synchronous RAM, quaternion rotation and a
// pipelined brute-force nearest search. Depends on nds_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------------
//  req     | in        | req_valid/req_stall| req_type, point_x/y/z, query_w/x/y/z
//  rsp     | out       | rsp_valid/rsp_stall| status, nearest_index, stored_count
//
// Steps: load, clear and the unused code go through S_DONE to the response register. A query
// runs S_ROT_MUL, S_ROT_SUM and S_ROT_RND for the rotation, one RAM read per stored point in
// S_SCAN, S_DRAIN for the read/square/sum/compare pipeline and S_DONE to post the response.
// The single RAM read port sets the scan rate of one point per cycle.
// Reset clears the control state and the point count; the RAM is not cleared, since only
// entries below the count are read. req_stall is high while a request is being worked on; a
// finished response can wait in its own register while the next request is accepted.
`default_nettype none

module nearest_direction_search_unit
    import nds_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [REQ_W-1:0]             req_type,
    input  wire logic signed [COMP_W-1:0]     point_x,
    input  wire logic signed [COMP_W-1:0]     point_y,
    input  wire logic signed [COMP_W-1:0]     point_z,
    input  wire logic signed [COMP_W-1:0]     query_w,
    input  wire logic signed [COMP_W-1:0]     query_x,
    input  wire logic signed [COMP_W-1:0]     query_y,
    input  wire logic signed [COMP_W-1:0]     query_z,

    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic [STATUS_W-1:0]               status,
    output logic [IDX_OUT_W-1:0]              nearest_index,
    output logic [CNT_OUT_W-1:0]              stored_count
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;   // table address
    localparam int CW = $clog2(MAX_POINTS + 1);                         // point count

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              scan_reg, scan_next;

    // query quaternion and rotated target
    logic signed [COMP_W-1:0]   qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [PROD_W-1:0]   p_xz_reg, p_wy_reg, p_yz_reg, p_wx_reg;
    logic signed [PROD_W-1:0]   p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [COMP_W-1:0]   tx_reg, ty_reg, tz_reg;

    // scan pipeline: RAM data, squares, distance
    logic                       rd_valid_reg, sq_valid_reg, dist_valid_reg;
    logic [AW-1:0]              rd_idx_reg, sq_idx_reg, dist_idx_reg;
    point_t                     mem_rd_reg;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]          dist_reg;
    logic [DIST_W-1:0]          best_dist_reg, best_dist_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;

    // pending result and response register
    status_t                    res_status_reg, res_status_next;
    logic [AW-1:0]              res_idx_reg, res_idx_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    status_t                    rsp_status_reg;
    logic [AW-1:0]              rsp_idx_reg;
    logic [CW-1:0]              rsp_count_reg;

    // ------------------------------------------------------------------
    // Point table
    // ------------------------------------------------------------------
    point_t                     mem [MAX_POINTS];
    logic                       mem_we;
    point_t                     mem_wdata;

    logic                       req_acc;
    logic                       table_full;
    logic                       rsp_free;
    logic                       best_upd;
    logic [CW-1:0]              count_m1;
    logic [AW-1:0]              scan_last;
    logic signed [DIFF_W-1:0]   ex, ey, ez;
    logic signed [2*DIFF_W-1:0] ex_sq, ey_sq, ez_sq;
    logic [CW+CNT_OUT_W-1:0]    count_ext;
    logic [AW+IDX_OUT_W-1:0]    idx_ext;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_acc    = req_valid && !req_stall;
    assign table_full = (count_reg >= CW'(MAX_POINTS));
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign count_m1   = count_reg - CW'(1);
    assign scan_last  = count_m1[AW-1:0];

    assign mem_wdata.x = point_x;
    assign mem_wdata.y = point_y;
    assign mem_wdata.z = point_z;
    assign mem_we      = req_acc && (req_type == REQ_LOAD) && !table_full;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= mem_wdata;
        end
        if (state_reg == S_SCAN)
        begin
            mem_rd_reg <= mem[scan_reg];
        end
    end

    // first entry always wins, later ones only when strictly closer
    assign best_upd = dist_valid_reg && ((dist_idx_reg == '0) || (dist_reg < best_dist_reg));
    assign best_dist_next = best_upd ? dist_reg : best_dist_reg;
    assign best_idx_next  = best_upd ? dist_idx_reg : best_idx_reg;

    // differences and squares against the rotated target
    assign ex    = DIFF_W'(mem_rd_reg.x) - DIFF_W'(tx_reg);
    assign ey    = DIFF_W'(mem_rd_reg.y) - DIFF_W'(ty_reg);
    assign ez    = DIFF_W'(mem_rd_reg.z) - DIFF_W'(tz_reg);
    assign ex_sq = ex * ex;
    assign ey_sq = ey * ey;
    assign ez_sq = ez * ez;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    res_status_next = ST_OK;
                    res_idx_next    = '0;
                    state_next      = S_DONE;
                    case (req_type)
                        REQ_LOAD:
                        begin
                            if (table_full)
                                res_status_next = ST_FULL;
                            else
                                count_next = count_reg + CW'(1);
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_QUERY:
                        begin
                            if (count_reg == '0)
                                res_status_next = ST_EMPTY;
                            else
                                state_next = S_ROT_MUL;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ROT_MUL:
            begin
                state_next = S_ROT_SUM;
            end
            S_ROT_SUM:
            begin
                state_next = S_ROT_RND;
            end
            S_ROT_RND:
            begin
                scan_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_reg == scan_last)
                    state_next = S_DRAIN;
                else
                    scan_next = scan_reg + AW'(1);
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !sq_valid_reg && !dist_valid_reg)
                begin
                    res_idx_next = best_idx_reg;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            rd_valid_reg   <= (state_reg == S_SCAN);
            sq_valid_reg   <= rd_valid_reg;
            dist_valid_reg <= sq_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        scan_reg        <= scan_next;
        res_status_reg  <= res_status_next;
        res_idx_reg     <= res_idx_next;
        best_dist_reg   <= best_dist_next;
        best_idx_reg    <= best_idx_next;

        if (req_acc)
        begin
            qw_reg <= query_w;
            qx_reg <= query_x;
            qy_reg <= query_y;
            qz_reg <= query_z;
        end

        // rotation of the z unit vector: q * (0,0,1) * conj(q)
        p_xz_reg <= qx_reg * qz_reg;
        p_wy_reg <= qw_reg * qy_reg;
        p_yz_reg <= qy_reg * qz_reg;
        p_wx_reg <= qw_reg * qx_reg;
        p_ww_reg <= qw_reg * qw_reg;
        p_xx_reg <= qx_reg * qx_reg;
        p_yy_reg <= qy_reg * qy_reg;
        p_zz_reg <= qz_reg * qz_reg;

        sum_x_reg <= (SUM_W'(p_xz_reg) + SUM_W'(p_wy_reg)) <<< 1;
        sum_y_reg <= (SUM_W'(p_yz_reg) - SUM_W'(p_wx_reg)) <<< 1;
        sum_z_reg <= SUM_W'(p_ww_reg) - SUM_W'(p_xx_reg) - SUM_W'(p_yy_reg)
                     + SUM_W'(p_zz_reg);

        if (state_reg == S_ROT_RND)
        begin
            tx_reg <= round_sat(sum_x_reg);
            ty_reg <= round_sat(sum_y_reg);
            tz_reg <= round_sat(sum_z_reg);
        end

        rd_idx_reg   <= scan_reg;
        sq_idx_reg   <= rd_idx_reg;
        dist_idx_reg <= sq_idx_reg;
        sqx_reg      <= ex_sq[SQ_W-1:0];
        sqy_reg      <= ey_sq[SQ_W-1:0];
        sqz_reg      <= ez_sq[SQ_W-1:0];
        dist_reg     <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);

        if ((state_reg == S_DONE) && rsp_free)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_idx_reg    <= res_idx_reg;
            rsp_count_reg  <= count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Response port
    // ------------------------------------------------------------------
    assign count_ext     = {{CNT_OUT_W{1'b0}}, rsp_count_reg};
    assign idx_ext       = {{IDX_OUT_W{1'b0}}, rsp_idx_reg};
    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign nearest_index = idx_ext[IDX_OUT_W-1:0];
    assign stored_count  = count_ext[CNT_OUT_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count above table size");

    a_load_incr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted load did not advance the count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (CW'(rd_idx_reg) < count_reg))
        else $error("scan read beyond stored points");

    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != ST_OK)) |-> (nearest_index == '0))
        else $error("nonzero index on a failed request");

    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!rd_valid_reg && !sq_valid_reg && !dist_valid_reg))
        else $error("scan pipeline busy while idle");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for nearest_direction_search_unit: a directed table of requests, then random requests under
// changing idle rates, checked against typed values or a behavioral table-and-search predictor.
// Depends on nds_pkg and the unit RTL.
`default_nettype none

module tb;
    import nds_pkg::*;

    localparam int TABLE_DEPTH    = DEF_MAX_POINTS;
    localparam int WATCHDOG_LIMIT = 20000;   // quiet cycles
    localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic signed [COMP_W-1:0] px, py, pz;
        logic signed [COMP_W-1:0] qw, qx, qy, qz;
    } request_t;

    typedef struct packed {
        status_t              st;
        logic [IDX_OUT_W-1:0] idx;
        logic [CNT_OUT_W-1:0] cnt;
    } search_result_t;

    typedef struct packed {
        request_t       req;
        logic           typed;
        search_result_t want;
    } directed_row_t;

    localparam search_result_t NO_RESULT = '0;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [REQ_W-1:0]         req_type;
    logic signed [COMP_W-1:0] point_x, point_y, point_z;
    logic signed [COMP_W-1:0] query_w, query_x, query_y, query_z;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [STATUS_W-1:0]      status;
    logic [IDX_OUT_W-1:0]     nearest_index;
    logic [CNT_OUT_W-1:0]     stored_count;

    // Predictor state: stored directions and their count.
    point_t         dir_table [TABLE_DEPTH];
    int             dir_count = 0;
    search_result_t expected_results [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_pending = 1'b0;
    int fail_count   = 0;

    always #5 clk = ~clk;

    nearest_direction_search_unit #(
        .MAX_POINTS(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .query_w(query_w),
        .query_x(query_x),
        .query_y(query_y),
        .query_z(query_z),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status(status),
        .nearest_index(nearest_index),
        .stored_count(stored_count)
    );

    // Q2.28 sum to Q1.14: round half up (toward +inf), then clamp to 16 bits signed.
    function automatic logic signed [COMP_W-1:0] q28_to_q14(input longint s);
        longint r;
        r = (s + 8192) >>> RND_SHIFT;
        if (r > 32767)
            return 16'sh7fff;
        if (r < -32768)
            return 16'sh8000;
        return r[COMP_W-1:0];
    endfunction

    // Updates the table for one accepted request and returns the response it should give.
    function automatic search_result_t search_predict(input request_t r);
        search_result_t res;
        longint w, x, y, z;
        longint e, sq_dist, best;
        logic signed [COMP_W-1:0] rot [3];
        int i;
        res.st  = ST_OK;
        res.idx = '0;
        best    = 0;
        case (r.kind)
            REQ_LOAD:
                if (dir_count >= TABLE_DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    dir_table[dir_count].x = r.px;
                    dir_table[dir_count].y = r.py;
                    dir_table[dir_count].z = r.pz;
                    dir_count++;
                end
            REQ_CLEAR:
                dir_count = 0;
            REQ_QUERY:
                if (dir_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    w = r.qw;
                    x = r.qx;
                    y = r.qy;
                    z = r.qz;
                    // z unit vector rotated by q v q*, q not normalized
                    rot[0] = q28_to_q14(2 * (x * z + w * y));
                    rot[1] = q28_to_q14(2 * (y * z - w * x));
                    rot[2] = q28_to_q14(w * w - x * x - y * y + z * z);
                    for (i = 0; i < dir_count; i++)
                    begin
                        e       = longint'(dir_table[i].x) - longint'(rot[0]);
                        sq_dist = e * e;
                        e       = longint'(dir_table[i].y) - longint'(rot[1]);
                        sq_dist = sq_dist + e * e;
                        e       = longint'(dir_table[i].z) - longint'(rot[2]);
                        sq_dist = sq_dist + e * e;
                        // strict less-than: earliest index wins a tie
                        if (i == 0 || sq_dist < best)
                        begin
                            best    = sq_dist;
                            res.idx = IDX_OUT_W'(i);
                        end
                    end
                end
            default: ;  // unused code leaves the table alone
        endcase
        res.cnt = CNT_OUT_W'(dir_count);
        return res;
    endfunction

    function automatic logic signed [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return COMP_W'(int'($urandom_range(0, 32768)) - 16384);
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // Mostly loads and queries on a small table; clears keep it short so scans stay cheap.
    function automatic request_t random_request();
        request_t r;
        int pick;
        int src;
        r.px = rand_comp();
        r.py = rand_comp();
        r.pz = rand_comp();
        r.qw = rand_comp();
        r.qx = rand_comp();
        r.qy = rand_comp();
        r.qz = rand_comp();
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.kind = REQ_UNUSED;
        else if (pick < 9 || (dir_count > 40 && pick < 30))
            r.kind = REQ_CLEAR;
        else if (pick < 52)
            r.kind = REQ_LOAD;
        else
            r.kind = REQ_QUERY;
        // repeated points force ties in the scan
        if (r.kind == REQ_LOAD && dir_count > 0 && $urandom_range(0, 99) < 15)
        begin
            src  = $urandom_range(0, dir_count - 1);
            r.px = dir_table[src].x;
            r.py = dir_table[src].y;
            r.pz = dir_table[src].z;
        end
        return r;
    endfunction

    // Fields a request does not use carry noise.
    function automatic directed_row_t dir_row(input logic [REQ_W-1:0] kind,
                                              input int a, b, c, d,
                                              input bit typed, input status_t st,
                                              input int idx, cnt);
        directed_row_t row;
        row.req.kind = kind;
        row.req.px   = COMP_W'($urandom);
        row.req.py   = COMP_W'($urandom);
        row.req.pz   = COMP_W'($urandom);
        row.req.qw   = COMP_W'($urandom);
        row.req.qx   = COMP_W'($urandom);
        row.req.qy   = COMP_W'($urandom);
        row.req.qz   = COMP_W'($urandom);
        if (kind == REQ_LOAD)
        begin
            row.req.px = COMP_W'(a);
            row.req.py = COMP_W'(b);
            row.req.pz = COMP_W'(c);
        end
        else if (kind == REQ_QUERY)
        begin
            row.req.qw = COMP_W'(a);
            row.req.qx = COMP_W'(b);
            row.req.qy = COMP_W'(c);
            row.req.qz = COMP_W'(d);
        end
        row.typed    = typed;
        row.want.st  = st;
        row.want.idx = IDX_OUT_W'(idx);
        row.want.cnt = CNT_OUT_W'(cnt);
        return row;
    endfunction

    // Drives one request from a falling edge, holds it until accepted, returns at a falling edge.
    task automatic send_request(input request_t r, input bit typed, input search_result_t want);
        search_result_t predicted;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_type  = r.kind;
        point_x   = r.px;
        point_y   = r.py;
        point_z   = r.pz;
        query_w   = r.qw;
        query_x   = r.qx;
        query_y   = r.qy;
        query_z   = r.qz;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = search_predict(r);
        expected_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Requests with the unused code, which leave the table alone, are not counted.
    task automatic run_random(input int n);
        request_t r;
        int done;
        done = 0;
        while (done < n)
        begin
            r = random_request();
            send_request(r, PREDICTED, NO_RESULT);
            if (r.kind != REQ_UNUSED)
                done++;
        end
    endtask

    // Receiver: random stalls, or one long hold-off counted here when asked for.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_stall    = 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
                rsp_stall = ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Response check against the oldest pending expectation.
    always @(posedge clk)
    begin : rsp_check
        search_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: response with nothing pending: status %0d index %0d count %0d",
                         $time, status, nearest_index, stored_count);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    fail_count++;
                end
                if (nearest_index !== want.idx)
                begin
                    $display("%0t: nearest_index expected %0d actual %0d",
                             $time, want.idx, nearest_index);
                    fail_count++;
                end
                if (stored_count !== want.cnt)
                begin
                    $display("%0t: stored_count expected %0d actual %0d",
                             $time, want.cnt, stored_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles with no handshake on either channel ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL nearest_direction_search_unit");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t directed_rows [$];
        int            k;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_type  = '0;
        point_x   = '0;
        point_y   = '0;
        point_z   = '0;
        query_w   = '0;
        query_x   = '0;
        query_y   = '0;
        query_z   = '0;

        // Directed rows: trivially known responses are typed in, the rest use the predictor.
        directed_rows.push_back(dir_row(REQ_QUERY, 16384, 0, 0, 0, TYPED, ST_EMPTY, 0, 0));
        directed_rows.push_back(dir_row(REQ_UNUSED, 0, 0, 0, 0, TYPED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_CLEAR, 0, 0, 0, 0, TYPED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_LOAD, 32767, 32767, 32767, 0, TYPED, ST_OK, 0, 1));
        directed_rows.push_back(dir_row(REQ_LOAD, -32768, -32768, -32768, 0,
                                        TYPED, ST_OK, 0, 2));
        directed_rows.push_back(dir_row(REQ_LOAD, 0, 0, 16384, 0, TYPED, ST_OK, 0, 3));
        directed_rows.push_back(dir_row(REQ_LOAD, 0, 0, 16384, 0, TYPED, ST_OK, 0, 4));
        // identity rotation hits both copies of +z: earliest one wins
        directed_rows.push_back(dir_row(REQ_QUERY, 16384, 0, 0, 0, TYPED, ST_OK, 2, 4));
        directed_rows.push_back(dir_row(REQ_QUERY, 0, 0, 0, 0, PREDICTED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_QUERY, -32768, -32768, -32768, -32768,
                                        PREDICTED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_QUERY, 32767, 32767, 32767, 32767,
                                        PREDICTED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_QUERY, 32767, -32768, 32767, -32768,
                                        PREDICTED, ST_OK, 0, 0));
        // x component saturates low
        directed_rows.push_back(dir_row(REQ_QUERY, 0, 32767, 0, -32768, PREDICTED, ST_OK, 0, 0));
        // exact halves: +0.5 rounds up, -0.5 rounds to zero
        directed_rows.push_back(dir_row(REQ_QUERY, 64, 0, 0, 64, PREDICTED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_QUERY, 0, 64, 64, 0, PREDICTED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_UNUSED, 0, 0, 0, 0, TYPED, ST_OK, 0, 4));
        directed_rows.push_back(dir_row(REQ_LOAD, -1, 0, 1, 0, TYPED, ST_OK, 0, 5));
        directed_rows.push_back(dir_row(REQ_QUERY, 0, -32768, 0, 0, PREDICTED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_CLEAR, 0, 0, 0, 0, TYPED, ST_OK, 0, 0));
        directed_rows.push_back(dir_row(REQ_QUERY, 1, 2, 3, 4, TYPED, ST_EMPTY, 0, 0));
        directed_rows.push_back(dir_row(REQ_LOAD, 21845, -21846, 1, 0, TYPED, ST_OK, 0, 1));
        directed_rows.push_back(dir_row(REQ_QUERY, -21846, 21845, -21846, 21845,
                                        TYPED, ST_OK, 0, 1));
        directed_rows.push_back(dir_row(REQ_CLEAR, 0, 0, 0, 0, TYPED, ST_OK, 0, 0));

        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        snd_idle_pct = 26;
        rcv_idle_pct = 54;
        for (k = 0; k < directed_rows.size(); k++)
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
        run_random(200);

        // Receiver holds off while requests keep coming, so the unit backs up.
        snd_idle_pct = 54;
        rcv_idle_pct = 26;
        hold_pending = 1'b1;
        run_random(180);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(150);
        req_valid = 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 16)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS nearest_direction_search_unit");
        else
            $display("FAIL nearest_direction_search_unit");
        $finish;
    end

endmodule

`default_nettype wire
